// ----- rtl/rnp_pkg.sv -----
// Package for the ring-tone note parser: types, codes, constants and the pitch table.
// Used by every other file of the block; depends on nothing.
package rnp_pkg;

  // Field widths of the channels and registers.
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DDUR_W   = 8;
  localparam int unsigned OCT_W    = 3;
  localparam int unsigned TEMPO_W  = 10;
  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned MS_W     = 19;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned DIVS_W   = TEMPO_W + DDUR_W;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_DEF_DURATION = 2'd0;
  localparam logic [1:0] REG_DEF_OCTAVE   = 2'd1;
  localparam logic [1:0] REG_TEMPO_BPM    = 2'd2;

  // Register reset values.
  localparam logic [DDUR_W-1:0]  DEF_DURATION_RST = 8'd4;
  localparam logic [OCT_W-1:0]   DEF_OCTAVE_RST   = 3'd5;
  localparam logic [TEMPO_W-1:0] TEMPO_RST        = 10'd63;

  // Whole-note time in ms, plain and dotted; the dotted value is also the answer for a zero divisor.
  localparam logic [MS_W-1:0] NUMER_PLAIN  = 19'd240000;
  localparam logic [MS_W-1:0] NUMER_DOTTED = 19'd360000;

  // Queue between parser and note unit.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Pitch index of a rest and the sharp flag within the index.
  localparam logic [IDX_W-1:0] REST_INDEX = 4'd7;
  localparam int unsigned      SHARP_BIT  = 3;

  // Character codes the parser looks for.
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_FOUR  = 8'h34;
  localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Divider iteration count: one quotient bit per cycle.
  localparam int unsigned      DIV_STEPS = MS_W;
  localparam int unsigned      DCNT_W    = $clog2(DIV_STEPS);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DIGITS,
    PH_LETTER,
    PH_SHARP,
    PH_DOT,
    PH_OCTAVE,
    PH_FINAL
  } parse_phase_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SETUP,
    BK_DIVIDE,
    BK_HOLD
  } back_state_e;

  // One parsed note request handed from the parser to the note unit.
  typedef struct packed {
    logic              note_valid;
    logic              tune_done;
    logic [IDX_W-1:0]  note_index;
    logic [OCT_W-1:0]  octave;
    logic [DDUR_W-1:0] duration;
    logic              dotted;
  } note_cmd_t;

  // Configuration seen by the note unit.
  typedef struct packed {
    logic [DDUR_W-1:0]  default_duration;
    logic [OCT_W-1:0]   default_octave;
    logic [TEMPO_W-1:0] tempo_bpm;
  } cfg_t;

  // Pitch in tenths of Hz for octave four; the upper half holds the sharps.
  function automatic logic [FREQ_W-1:0] pitch_lookup(input logic [IDX_W-1:0] idx);
    logic [FREQ_W-1:0] p;
    case (idx)
      4'd0:    p = 16'd4400;
      4'd1:    p = 16'd4939;
      4'd2:    p = 16'd2616;
      4'd3:    p = 16'd2937;
      4'd4:    p = 16'd3296;
      4'd5:    p = 16'd3492;
      4'd6:    p = 16'd3920;
      4'd8:    p = 16'd4662;
      4'd10:   p = 16'd2772;
      4'd11:   p = 16'd3111;
      4'd13:   p = 16'd3700;
      4'd14:   p = 16'd4153;
      default: p = '0;
    endcase
    return p;
  endfunction

  // Letter slot: a..g by position, h as b, anything else a rest.
  function automatic logic [IDX_W-1:0] letter_index(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] lc;
    logic [IDX_W-1:0]  r;
    lc = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      lc = c + 8'd32;
    end
    if (lc >= 8'h61 && lc <= 8'h67) begin
      r = IDX_W'(lc - 8'h61);
    end else if (lc == 8'h68) begin
      r = 4'd1;
    end else begin
      r = REST_INDEX;
    end
    return r;
  endfunction

endpackage

// ----- rtl/rnp_in_if.sv -----
// Character channel of the ring-tone note parser: valid/ready plus one character.
// Depends on rnp_pkg.
interface rnp_in_if;
  logic                       valid;
  logic                       ready;
  logic [rnp_pkg::CHAR_W-1:0] char_code;
  logic                       end_of_tune;

  modport source (output valid, output char_code, output end_of_tune, input ready);
  modport sink (input valid, input char_code, input end_of_tune, output ready);
endinterface

// ----- rtl/rnp_out_if.sv -----
// Note channel of the ring-tone note parser: valid/ready plus one note result.
// Depends on rnp_pkg.
interface rnp_out_if;
  logic                       valid;
  logic                       ready;
  logic                       note_valid;
  logic                       tune_done;
  logic [rnp_pkg::FREQ_W-1:0] frequency_tenths_hz;
  logic [rnp_pkg::MS_W-1:0]   duration_ms;

  modport source (output valid, output note_valid, output tune_done,
                  output frequency_tenths_hz, output duration_ms, input ready);
  modport sink (input valid, input note_valid, input tune_done,
                input frequency_tenths_hz, input duration_ms, output ready);
endinterface

// ----- rtl/rnp_front.sv -----
// Character parser of the ring-tone note parser: one character per cycle while the queue has room, emits note requests.
// Depends on rnp_pkg and rnp_in_if.
module rnp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  rnp_in_if.sink              in_i,
  input  logic                full_i,
  output logic                push_o,
  output rnp_pkg::note_cmd_t  cmd_o
);
  import rnp_pkg::*;

  parse_phase_e       phase_q, phase_d;
  logic [DDUR_W-1:0]  accum_q, accum_d;
  logic [IDX_W-1:0]   index_q, index_d;
  logic [OCT_W-1:0]   octave_q, octave_d;
  logic               dotted_q, dotted_d;

  logic               fire;
  logic               is_digit;
  logic               is_oct;
  logic [CHAR_W-1:0]  c;
  logic [DDUR_W-1:0]  digit;
  logic [11:0]        accum_next;
  logic               emit;
  logic               clear;

  assign in_i.ready = !full_i;
  assign fire       = in_i.valid && in_i.ready;
  assign c          = in_i.char_code;
  assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_oct     = (c >= CH_FOUR) && (c <= CH_SEVEN);
  assign digit      = c - CH_ZERO;
  assign accum_next = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} + {4'b0000, digit};

  // Parse one character and decide whether the pending note is finished.
  always_comb begin
    phase_d  = phase_q;
    accum_d  = accum_q;
    index_d  = index_q;
    octave_d = octave_q;
    dotted_d = dotted_q;
    emit     = 1'b0;
    clear    = 1'b0;
    push_o   = 1'b0;
    cmd_o.note_valid = 1'b1;
    cmd_o.tune_done  = 1'b0;
    cmd_o.note_index = index_q;
    cmd_o.octave     = octave_q;
    cmd_o.duration   = accum_q;
    cmd_o.dotted     = dotted_q;

    if (fire) begin
      if (in_i.end_of_tune) begin
        // Flush whatever is pending; bare digits become a rest.
        push_o = 1'b1;
        clear  = 1'b1;
        cmd_o.tune_done  = 1'b1;
        cmd_o.note_valid = (phase_q != PH_IDLE);
        if (phase_q == PH_DIGITS) begin
          cmd_o.note_index = REST_INDEX;
        end
      end else begin
        case (phase_q)
          PH_IDLE: begin
            if (c == CH_SPACE || c == CH_COMMA) begin
              phase_d = PH_IDLE;
            end else if (is_digit) begin
              accum_d = digit;
              phase_d = PH_DIGITS;
            end else begin
              index_d = letter_index(c);
              phase_d = PH_LETTER;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              accum_d = (accum_next > 12'd255) ? 8'd255 : accum_next[DDUR_W-1:0];
            end else begin
              index_d = letter_index(c);
              phase_d = PH_LETTER;
            end
          end
          PH_LETTER: begin
            if (c == CH_HASH) begin
              index_d[SHARP_BIT] = 1'b1;
              phase_d = PH_SHARP;
            end else if (c == CH_DOT) begin
              dotted_d = 1'b1;
              phase_d  = PH_DOT;
            end else if (is_oct) begin
              octave_d = digit[OCT_W-1:0];
              phase_d  = PH_OCTAVE;
            end else begin
              emit = 1'b1;
            end
          end
          PH_SHARP: begin
            if (c == CH_DOT) begin
              dotted_d = 1'b1;
              phase_d  = PH_DOT;
            end else if (is_oct) begin
              octave_d = digit[OCT_W-1:0];
              phase_d  = PH_OCTAVE;
            end else begin
              emit = 1'b1;
            end
          end
          PH_DOT: begin
            if (is_oct) begin
              octave_d = digit[OCT_W-1:0];
              phase_d  = PH_OCTAVE;
            end else if (c == CH_DOT) begin
              phase_d = PH_FINAL;
            end else begin
              emit = 1'b1;
            end
          end
          PH_OCTAVE: begin
            if (c == CH_DOT) begin
              dotted_d = 1'b1;
              phase_d  = PH_FINAL;
            end else begin
              emit = 1'b1;
            end
          end
          default: begin
            emit = 1'b1;
          end
        endcase
        if (emit) begin
          push_o = 1'b1;
          clear  = 1'b1;
        end
      end
    end

    if (clear) begin
      phase_d  = PH_IDLE;
      accum_d  = '0;
      index_d  = '0;
      octave_d = '0;
      dotted_d = 1'b0;
    end
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      accum_q  <= '0;
      index_q  <= '0;
      octave_q <= '0;
      dotted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      accum_q  <= accum_d;
      index_q  <= index_d;
      octave_q <= octave_d;
      dotted_q <= dotted_d;
    end
  end

  // The end of a tune always leaves the parser cleared.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_i.end_of_tune |=> phase_q == PH_IDLE && accum_q == '0)
    else $error("parser not cleared after end of tune");

  // A character is taken only while the queue has room.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("note request pushed into a full queue");

  // Only the digit phase holds a duration without a letter behind it.
  a_accum_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> accum_q == '0 && dotted_q == 1'b0)
    else $error("idle parser holds note fields");

endmodule

// ----- rtl/rnp_queue.sv -----
// Two-entry request queue between the parser and the note unit of the ring-tone parser.
// Depends on rnp_pkg.
module rnp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rnp_pkg::note_cmd_t  cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output rnp_pkg::note_cmd_t  cmd_o,
  output logic                empty_o
);
  import rnp_pkg::*;

  note_cmd_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entry_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // The fill count never passes the depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count out of range");

  // Pointers agree with the count when the queue is empty.
  a_ptr_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree while empty");

  // A lone push raises the count by one.
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count missed a push");

endmodule

// ----- rtl/rnp_back.sv -----
// Note unit of the ring-tone note parser: pitch lookup, tempo product and a serial
// restoring divider for the note length. Depends on rnp_pkg and rnp_out_if.
module rnp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  rnp_pkg::note_cmd_t  cmd_i,
  output logic                pop_o,
  input  rnp_pkg::cfg_t       cfg_i,
  rnp_out_if.source           out_o
);
  import rnp_pkg::*;

  back_state_e        state_q, state_d;
  note_cmd_t          cmd_q;
  logic [FREQ_W-1:0]  freq_q;
  logic [DIVS_W-1:0]  divisor_q;
  logic [MS_W-1:0]    numer_q;
  logic [MS_W-1:0]    quot_q;
  logic [DIVS_W-1:0]  rem_q;
  logic [DCNT_W-1:0]  cnt_q;

  logic [OCT_W-1:0]   oct_pick;
  logic [OCT_W-1:0]   oct_eff;
  logic [DDUR_W-1:0]  dur_eff;
  logic [DIVS_W-1:0]  product;
  logic [DIVS_W:0]    rem_shift;
  logic [DIVS_W:0]    rem_diff;
  logic               ge;

  // Resolve defaults for octave and duration, raise octaves below four to four, and form the product.
  assign oct_pick = (cmd_q.octave != '0) ? cmd_q.octave : cfg_i.default_octave;
  assign oct_eff  = (oct_pick < 3'd4) ? 3'd4 : oct_pick;
  assign dur_eff  = (cmd_q.duration != '0) ? cmd_q.duration : cfg_i.default_duration;
  assign product  = DIVS_W'(cfg_i.tempo_bpm * dur_eff);

  // One restoring step: bring down the next numerator bit and try a subtract.
  assign rem_shift = {rem_q, numer_q[MS_W-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor_q};
  assign ge        = (rem_shift >= {1'b0, divisor_q});

  assign pop_o = (state_q == BK_IDLE) && !empty_i;

  // Result register drives the channel while the state holds it.
  assign out_o.valid               = (state_q == BK_HOLD);
  assign out_o.note_valid          = cmd_q.note_valid;
  assign out_o.tune_done           = cmd_q.tune_done;
  assign out_o.frequency_tenths_hz = cmd_q.note_valid ? freq_q : '0;
  assign out_o.duration_ms         = cmd_q.note_valid ? quot_q : '0;

  // Next-state logic of the note unit.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          state_d = BK_SETUP;
        end
      end
      BK_SETUP: begin
        state_d = (product == '0) ? BK_HOLD : BK_DIVIDE;
      end
      BK_DIVIDE: begin
        if (cnt_q == '0) begin
          state_d = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_o.ready) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers: request, pitch, divisor and divider.
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          cmd_q <= cmd_i;
        end
      end
      BK_SETUP: begin
        freq_q    <= FREQ_W'(pitch_lookup(cmd_q.note_index) << (oct_eff - 3'd4));
        divisor_q <= product;
        numer_q   <= cmd_q.dotted ? NUMER_DOTTED : NUMER_PLAIN;
        rem_q     <= '0;
        cnt_q     <= DCNT_LAST;
        quot_q    <= NUMER_DOTTED;
      end
      BK_DIVIDE: begin
        rem_q   <= ge ? rem_diff[DIVS_W-1:0] : rem_shift[DIVS_W-1:0];
        quot_q  <= {quot_q[MS_W-2:0], ge};
        numer_q <= {numer_q[MS_W-2:0], 1'b0};
        cnt_q   <= cnt_q - 1'b1;
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  // The divider never runs on a zero divisor.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DIVIDE |-> divisor_q != '0)
    else $error("divider running with zero divisor");

  // The partial remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DIVIDE |-> rem_q < divisor_q)
    else $error("divider remainder out of range");

  // A result without a note carries zero pitch and length.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.note_valid |->
      out_o.frequency_tenths_hz == '0 && out_o.duration_ms == '0)
    else $error("result without note carries data");

  // A request is taken from the queue only when the unit is free.
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == BK_SETUP)
    else $error("request popped without starting");

endmodule

// ----- rtl/ringtone_note_parser_top.sv -----
// Ring-tone note parser: turns the note section of a ring-tone string, one character per
// request, into notes with pitch in tenths of Hz and length in ms. The parser takes one
// character per cycle while its two-entry queue has room. The note unit picks up a request,
// looks up the pitch and forms the tempo-times-duration product, runs the serial restoring
// divider for the note length (one quotient bit per cycle, skipped for a zero divisor) and
// holds the result until it is handed over. Defaults and tempo are written over the
// APB-style port at byte addresses 0, 4 and 8; write them only while the block is idle.
// Depends on rnp_pkg, rnp_in_if, rnp_out_if, rnp_front, rnp_queue and rnp_back.
module ringtone_note_parser_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rnp_in_if.sink                      in_i,
  rnp_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rnp_pkg::PADDR_W-1:0] paddr,
  input  logic [rnp_pkg::PDATA_W-1:0] pwdata,
  output logic [rnp_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import rnp_pkg::*;

  logic [DDUR_W-1:0]  def_dur_q;
  logic [OCT_W-1:0]   def_oct_q;
  logic [TEMPO_W-1:0] tempo_q;
  logic               cfg_wr;
  logic [1:0]         reg_sel;
  cfg_t               cfg;

  logic               push;
  logic               pop;
  logic               full;
  logic               empty;
  note_cmd_t          cmd_in;
  note_cmd_t          cmd_out;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_dur_q <= DEF_DURATION_RST;
      def_oct_q <= DEF_OCTAVE_RST;
      tempo_q   <= TEMPO_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_DEF_DURATION: def_dur_q <= pwdata[DDUR_W-1:0];
        REG_DEF_OCTAVE:   def_oct_q <= pwdata[OCT_W-1:0];
        REG_TEMPO_BPM:    tempo_q   <= pwdata[TEMPO_W-1:0];
        default:          tempo_q   <= tempo_q;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_sel)
      REG_DEF_DURATION: prdata = PDATA_W'(def_dur_q);
      REG_DEF_OCTAVE:   prdata = PDATA_W'(def_oct_q);
      REG_TEMPO_BPM:    prdata = PDATA_W'(tempo_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg.default_duration = def_dur_q;
  assign cfg.default_octave   = def_oct_q;
  assign cfg.tempo_bpm        = tempo_q;

  // Parser, request queue and note unit.
  rnp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  rnp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .empty_o (empty)
  );

  rnp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (cmd_out),
    .pop_o   (pop),
    .cfg_i   (cfg),
    .out_o   (out_o)
  );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the ring-tone note parser: drives characters and tune ends,
// predicts each note result and checks it field by field. Depends on rnp_pkg, rnp_in_if,
// rnp_out_if and ringtone_note_parser_top.
`timescale 1ns / 1ps

module tb_top;
  import rnp_pkg::*;

  localparam int unsigned PHASE_COUNT  = 8;
  localparam int unsigned PHASE_CHARS  = 60;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned WAIT_MAX     = 18;

  // Handshake pacing styles.
  localparam int unsigned PACE_NONE   = 0;
  localparam int unsigned PACE_HEAVY  = 1;
  localparam int unsigned PACE_SPARSE = 2;

  // Letter range limits for the letter slot.
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_G = 8'h67;
  localparam logic [CHAR_W-1:0] CH_LOWER_H = 8'h68;
  localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

  // Octave-four pitch in tenths of Hz; the upper half holds the sharps.
  localparam logic [FREQ_W-1:0] TONE_TENTHS_HZ [16] = '{
    16'd4400, 16'd4939, 16'd2616, 16'd2937, 16'd3296, 16'd3492, 16'd3920, 16'd0,
    16'd4662, 16'd0,    16'd2772, 16'd3111, 16'd0,    16'd3700, 16'd4153, 16'd0
  };

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              eot;
  } tune_char_t;

  typedef struct packed {
    logic              note_valid;
    logic              tune_done;
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0]   ms;
  } note_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  rnp_in_if  char_if ();
  rnp_out_if note_if ();

  ringtone_note_parser_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (char_if),
    .out_o   (note_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies used for prediction.
  logic [DDUR_W-1:0]  cfg_def_duration = DEF_DURATION_RST;
  logic [OCT_W-1:0]   cfg_def_octave   = DEF_OCTAVE_RST;
  logic [TEMPO_W-1:0] cfg_tempo        = TEMPO_RST;

  // Parser state as predicted.
  parse_phase_e      ps_phase  = PH_IDLE;
  logic [DDUR_W-1:0] ps_dur    = '0;
  logic [IDX_W-1:0]  ps_idx    = '0;
  logic [OCT_W-1:0]  ps_oct    = '0;
  logic              ps_dotted = 1'b0;

  tune_char_t   char_queue[$];
  note_result_t pending_notes[$];

  int unsigned chars_sent    = 0;
  int unsigned chars_taken   = 0;
  int unsigned chars_made    = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_wait     = 0;
  int unsigned recv_wait     = 0;
  int unsigned send_mode     = PACE_NONE;
  int unsigned recv_mode     = PACE_NONE;
  int unsigned quiet_cycles  = 0;

  function automatic int unsigned draw_wait(input int unsigned mode);
    if (mode == PACE_NONE) begin
      return 0;
    end else if (mode == PACE_HEAVY) begin
      return $urandom_range(0, WAIT_MAX);
    end
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, WAIT_MAX) : 0;
  endfunction

  function automatic logic [IDX_W-1:0] note_slot(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] lc;
    lc = (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ? ch + CASE_DIFF : ch;
    if (lc >= CH_LOWER_A && lc <= CH_LOWER_G) begin
      return IDX_W'(lc - CH_LOWER_A);
    end else if (lc == CH_LOWER_H) begin
      return IDX_W'(1);
    end
    return REST_INDEX;
  endfunction

  function automatic void clear_note();
    ps_phase  = PH_IDLE;
    ps_dur    = '0;
    ps_idx    = '0;
    ps_oct    = '0;
    ps_dotted = 1'b0;
  endfunction

  // Pitch and length of the note held in the parser state.
  function automatic note_result_t note_from_state();
    note_result_t r;
    logic [OCT_W-1:0] oct;
    int unsigned      dur;
    int unsigned      divisor;
    int unsigned      pitch;
    oct = (ps_oct != 0) ? ps_oct : cfg_def_octave;
    if (oct < 4) begin
      oct = 3'd4;
    end
    dur = 32'((ps_dur != 0) ? ps_dur : cfg_def_duration);
    divisor = 32'(cfg_tempo) * dur;
    pitch = 32'(TONE_TENTHS_HZ[ps_idx]) << (oct - 3'd4);
    r.note_valid = 1'b1;
    r.tune_done  = 1'b0;
    r.freq       = pitch[FREQ_W-1:0];
    if (divisor == 0) begin
      r.ms = NUMER_DOTTED;
    end else begin
      r.ms = MS_W'((ps_dotted ? 32'(NUMER_DOTTED) : 32'(NUMER_PLAIN)) / divisor);
    end
    return r;
  endfunction

  // Advance the parser by one request; returns 1 when a result is due.
  function automatic bit parse_char(input logic [CHAR_W-1:0] ch, input logic eot,
                                    output note_result_t res);
    bit          is_digit;
    bit          is_oct;
    bit          ends;
    int unsigned acc;
    is_digit = (ch >= CH_ZERO && ch <= CH_NINE);
    is_oct   = (ch >= CH_FOUR && ch <= CH_SEVEN);
    ends     = 1'b0;
    res      = '0;
    if (eot) begin
      // Bare duration digits still flush as a rest.
      if (ps_phase == PH_DIGITS) begin
        ps_idx = REST_INDEX;
        res = note_from_state();
      end else if (ps_phase != PH_IDLE) begin
        res = note_from_state();
      end
      res.tune_done = 1'b1;
      clear_note();
      return 1'b1;
    end
    case (ps_phase)
      PH_IDLE: begin
        if (ch != CH_SPACE && ch != CH_COMMA) begin
          if (is_digit) begin
            ps_dur = ch - CH_ZERO;
            ps_phase = PH_DIGITS;
          end else begin
            ps_idx = note_slot(ch);
            ps_phase = PH_LETTER;
          end
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          acc = 32'(ps_dur);
          acc = acc * 10 + 32'(ch - CH_ZERO);
          ps_dur = (acc > 255) ? 8'd255 : acc[DDUR_W-1:0];
        end else begin
          ps_idx = note_slot(ch);
          ps_phase = PH_LETTER;
        end
      end
      PH_LETTER: begin
        if (ch == CH_HASH) begin
          ps_idx = ps_idx + 4'd8;
          ps_phase = PH_SHARP;
        end else if (ch == CH_DOT) begin
          ps_dotted = 1'b1;
          ps_phase = PH_DOT;
        end else if (is_oct) begin
          ps_oct = OCT_W'(ch - CH_ZERO);
          ps_phase = PH_OCTAVE;
        end else begin
          ends = 1'b1;
        end
      end
      PH_SHARP: begin
        if (ch == CH_DOT) begin
          ps_dotted = 1'b1;
          ps_phase = PH_DOT;
        end else if (is_oct) begin
          ps_oct = OCT_W'(ch - CH_ZERO);
          ps_phase = PH_OCTAVE;
        end else begin
          ends = 1'b1;
        end
      end
      PH_DOT: begin
        if (is_oct) begin
          ps_oct = OCT_W'(ch - CH_ZERO);
          ps_phase = PH_OCTAVE;
        end else if (ch == CH_DOT) begin
          ps_phase = PH_FINAL;
        end else begin
          ends = 1'b1;
        end
      end
      PH_OCTAVE: begin
        if (ch == CH_DOT) begin
          ps_dotted = 1'b1;
          ps_phase = PH_FINAL;
        end else begin
          ends = 1'b1;
        end
      end
      default: begin
        ends = 1'b1;
      end
    endcase
    if (ends) begin
      res = note_from_state();
      clear_note();
    end
    return ends;
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Character driver: presents queued requests and predicts each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin : char_driver
    note_result_t res;
    tune_char_t   item;
    if (!rst_ni) begin
      char_if.valid       <= 1'b0;
      char_if.char_code   <= '0;
      char_if.end_of_tune <= 1'b0;
      send_wait = 0;
    end else begin
      if (char_if.valid && char_if.ready) begin
        if (parse_char(char_if.char_code, char_if.end_of_tune, res)) begin
          pending_notes.push_back(res);
        end
        chars_taken++;
        send_wait = draw_wait(send_mode);
        if ($urandom_range(0, 63) == 0) begin
          send_mode = $urandom_range(PACE_NONE, PACE_SPARSE);
        end
      end
      if (char_if.valid && !char_if.ready) begin
        // Hold the request until it is taken.
      end else if (send_wait != 0) begin
        char_if.valid <= 1'b0;
        send_wait--;
      end else if (char_queue.size() != 0) begin
        item = char_queue.pop_front();
        char_if.valid       <= 1'b1;
        char_if.char_code   <= item.code;
        char_if.end_of_tune <= item.eot;
      end else begin
        char_if.valid <= 1'b0;
      end
    end
  end

  // Note monitor: checks each accepted result and stalls ready at random.
  always @(posedge clk_i or negedge rst_ni) begin : note_monitor
    note_result_t want;
    if (!rst_ni) begin
      note_if.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (note_if.valid && note_if.ready) begin
        if (pending_notes.size() == 0) begin
          $error("note result with none pending: note_valid %0d tune_done %0d freq %0d ms %0d",
                 note_if.note_valid, note_if.tune_done, note_if.frequency_tenths_hz,
                 note_if.duration_ms);
          mismatch_count++;
        end else begin
          want = pending_notes.pop_front();
          compare_field("note_valid", 32'(want.note_valid), 32'(note_if.note_valid));
          compare_field("tune_done", 32'(want.tune_done), 32'(note_if.tune_done));
          compare_field("frequency_tenths_hz", 32'(want.freq),
                        32'(note_if.frequency_tenths_hz));
          compare_field("duration_ms", 32'(want.ms), 32'(note_if.duration_ms));
        end
        recv_wait = draw_wait(recv_mode);
        if ($urandom_range(0, 63) == 0) begin
          recv_mode = $urandom_range(PACE_NONE, PACE_SPARSE);
        end
      end
      if (recv_wait != 0) begin
        note_if.ready <= 1'b0;
        recv_wait--;
      end else begin
        note_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no request taken on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((char_if.valid && char_if.ready) || (note_if.valid && note_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  task automatic push_char(input logic [CHAR_W-1:0] code, input logic eot);
    tune_char_t item;
    item.code = code;
    item.eot  = eot;
    char_queue.push_back(item);
    chars_sent++;
    if (eot || (code != CH_SPACE && code != CH_COMMA)) begin
      chars_made++;
    end
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i], 1'b0);
    end
  endtask

  // One well-formed note with random content, now and then noise or a broken note.
  task automatic push_random_note();
    string             letters;
    int unsigned       pick;
    logic [CHAR_W-1:0] ch;
    letters = "abcdefghp";
    if ($urandom_range(0, 15) == 0) begin
      push_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
    end
    pick = $urandom_range(0, 9);
    if (pick >= 4 && pick <= 6) begin
      push_text($sformatf("%0d", 1 << $urandom_range(0, 5)));
    end else if (pick == 7) begin
      push_text($sformatf("%0d", $urandom_range(0, 99)));
    end else if (pick == 8) begin
      push_text($sformatf("%0d", $urandom_range(256, 99999)));
    end else if (pick == 9) begin
      push_text("0");
    end
    if ($urandom_range(0, 19) != 0) begin
      ch = letters[$urandom_range(0, 8)];
      if ($urandom_range(0, 1) == 1) begin
        ch = ch - CASE_DIFF;
      end
    end else begin
      ch = CHAR_W'($urandom_range(0, 255));
    end
    push_char(ch, 1'b0);
    if ($urandom_range(0, 99) < 35) push_char(CH_HASH, 1'b0);
    if ($urandom_range(0, 99) < 25) push_char(CH_DOT, 1'b0);
    if ($urandom_range(0, 99) < 60) push_char(CHAR_W'(CH_FOUR + $urandom_range(0, 3)), 1'b0);
    if ($urandom_range(0, 99) < 25) push_char(CH_DOT, 1'b0);
    pick = $urandom_range(0, 9);
    if (pick <= 4) begin
      push_char(CH_COMMA, 1'b0);
      if ($urandom_range(0, 1) == 1) push_char(CH_SPACE, 1'b0);
    end else if (pick <= 6) begin
      push_char(CH_SPACE, 1'b0);
    end else if (pick == 7) begin
      push_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
    end else if (pick == 8) begin
      push_char('0, 1'b1);
    end else begin
      push_text("|");
    end
  endtask

  // Waits until every request is taken and every note has come back.
  task automatic wait_drained();
    while (chars_taken != chars_sent || pending_notes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DEF_DURATION: cfg_def_duration = DDUR_W'(value);
      REG_DEF_OCTAVE:   cfg_def_octave   = OCT_W'(value);
      default:          cfg_tempo        = TEMPO_W'(value);
    endcase
  endtask

  task automatic write_config(input int unsigned dur, input int unsigned oct,
                              input int unsigned bpm);
    write_reg(REG_DEF_DURATION, dur);
    write_reg(REG_DEF_OCTAVE, oct);
    write_reg(REG_TEMPO_BPM, bpm);
  endtask

  // Main sequence: directed tune, then random tunes under several settings.
  initial begin : main_seq
    int unsigned start;
    rst_ni  <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Saturating digits, sharp, dots, double dot, h as b, unknown letter as rest,
    // zero duration, comma and bar ending a note, extreme codes, flush on tune end.
    push_text("999C#.7. 0h..,x4 16G5.|");
    push_char(8'hFF, 1'b0);
    push_char(8'h00, 1'b0);
    push_text("32");
    push_char('0, 1'b1);
    push_char(8'hFF, 1'b1);
    push_text("b");
    push_char('0, 1'b1);
    wait_drained();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: write_config(1, 4, 1);
        1: write_config(255, 7, 900);
        2: write_config(0, 0, 0);
        3: write_config(255, 3, 1023);
        4: write_config($urandom_range(1, 255), $urandom_range(4, 7), $urandom_range(1, 900));
        default: write_config($urandom_range(0, 255), $urandom_range(0, 7),
                              $urandom_range(0, 1023));
      endcase
      send_mode = $urandom_range(PACE_NONE, PACE_SPARSE);
      recv_mode = $urandom_range(PACE_NONE, PACE_SPARSE);
      start = chars_made;
      while (chars_made - start < PHASE_CHARS / 2) push_random_note();
      // On odd phases, hold the sender mid-tune until every note has come back.
      if (ph % 2 == 1) begin
        wait_drained();
      end
      while (chars_made - start < PHASE_CHARS) push_random_note();
      push_char('0, 1'b1);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
